[rtl/core/hbs_pkg.sv]
// Shared types, constants and index helpers for the heightmap bilinear sampler.
// Used by every module of the block. It has no dependencies of its own.
`default_nettype none

package hbs_pkg;

	// Grid and tile geometry.
	localparam int GRID_LOG2 = 6;
	localparam int TILE_LOG2 = 8;
	localparam int unsigned GRID_DIM = 1 << GRID_LOG2;
	localparam int ADDR_W = 2 * GRID_LOG2;
	localparam int unsigned STORE_DEPTH = 1 << ADDR_W;
	localparam int unsigned TILE_UNITS = 1 << TILE_LOG2;

	// Field widths.
	localparam int CFG_W = 7;
	localparam int SIZE_W = GRID_LOG2 + 1;
	localparam int COORD_W = 20;
	localparam int H_W = 16;
	localparam int FRAC_W = TILE_LOG2;
	localparam int WT1_W = TILE_LOG2 + 1;
	localparam int WT_W = 2 * TILE_LOG2 + 1;
	localparam int PROD_W = H_W + WT_W + 1;
	localparam int ACC_W = PROD_W + 1;
	localparam int IDX_W = COORD_W + 2;

	// Item kinds.
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// One classified item as it travels from the front part to the back part.
	typedef struct packed {
		logic                 kind;
		logic [GRID_LOG2-1:0] row;
		logic [GRID_LOG2-1:0] col;
		logic [FRAC_W-1:0]    frac_x;
		logic [FRAC_W-1:0]    frac_z;
		logic [H_W-1:0]       data;
	} hbs_item_t;

	// Back part sequencer states.
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_QUERY
	} hbs_state_t;

	// Saturate a size register to the range [2, GRID_DIM].
	function automatic logic [SIZE_W-1:0] eff_size(input logic [CFG_W-1:0] sz_reg);
		logic [SIZE_W-1:0] r;
		if (32'(sz_reg) < 32'd2) begin
			r = SIZE_W'(2);
		end else if (32'(sz_reg) > GRID_DIM) begin
			r = SIZE_W'(GRID_DIM);
		end else begin
			r = SIZE_W'(sz_reg);
		end
		return r;
	endfunction

	// Tile index of a coordinate, offset by half the size and clamped to [0, size-2].
	function automatic logic [GRID_LOG2-1:0] tile_index(
		input logic signed [COORD_W-1:0] coord,
		input logic [SIZE_W-1:0]         size
	);
		logic signed [IDX_W-1:0] ext;
		logic signed [IDX_W-1:0] t;
		logic signed [IDX_W-1:0] half;
		logic signed [IDX_W-1:0] lim;
		logic signed [IDX_W-1:0] idx;
		logic signed [IDX_W-1:0] r;
		ext = {{(IDX_W-COORD_W){coord[COORD_W-1]}}, coord};
		t = ext >>> TILE_LOG2;
		half = {{(IDX_W-SIZE_W){1'b0}}, size >> 1};
		lim = {{(IDX_W-SIZE_W){1'b0}}, size} - IDX_W'(2);
		idx = t + half;
		if (idx < 0) begin
			r = '0;
		end else if (idx > lim) begin
			r = lim;
		end else begin
			r = idx;
		end
		return r[GRID_LOG2-1:0];
	endfunction

endpackage

`default_nettype wire

[rtl/core/heightmap_bilinear_sampler_top.sv]
// Top level of the heightmap bilinear sampler: configuration registers and
// the front part, queue and back part. Depends on hbs_pkg and all hbs_ modules.
//
// Usage: the input channel (in_valid / in_stall) carries one transaction per
// item. kind = 0 stores write_height at (write_row, write_col); kind = 1 asks
// for the bilinear height at (coord_x, coord_z). Only queries produce an output
// transaction (out_valid / out_stall, field height).
// Store use: a query occupies the single-port height store with one read per
// neighbor; a queued query can start straight after the last read when a result
// slot is free, while one that starts from idle is first taken up in the idle
// state. A write takes one store write.
// Reset: grid_width and grid_height return to 40, then a clearing pass zeroes
// the 4096 store entries, during which in_stall stays high;
// APB writes are taken at all times.
// Receiver stall: two results can wait in the output buffer; beyond that the
// back part stops starting queries, the queue fills and in_stall rises.
`default_nettype none

module heightmap_bilinear_sampler_top
	import hbs_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [2:0]                paddr,
	input  wire logic [31:0]               pwdata,
	output logic      [31:0]               prdata,
	output logic                           pready,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic                      kind,
	input  wire logic signed [COORD_W-1:0] coord_x,
	input  wire logic signed [COORD_W-1:0] coord_z,
	input  wire logic [GRID_LOG2-1:0]      write_row,
	input  wire logic [GRID_LOG2-1:0]      write_col,
	input  wire logic signed [H_W-1:0]     write_height,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic signed [H_W-1:0]          height
);

	localparam logic REG_GRID_WIDTH  = 1'b0;
	localparam logic REG_GRID_HEIGHT = 1'b1;
	localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(40);

	logic [CFG_W-1:0] grid_width_q;
	logic [CFG_W-1:0] grid_height_q;
	logic             cfg_write;
	logic             clearing;
	logic             q_full;
	logic             q_empty;
	logic             q_push;
	logic             q_pop;
	hbs_item_t        q_item;
	hbs_item_t        q_head;

	// Configuration port: no wait states, register chosen by the word address.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= SIZE_RESET;
			grid_height_q <= SIZE_RESET;
		end else if (cfg_write) begin
			case (paddr[2])
				REG_GRID_WIDTH:  grid_width_q  <= pwdata[CFG_W-1:0];
				REG_GRID_HEIGHT: grid_height_q <= pwdata[CFG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Register read back.
	always_comb begin
		case (paddr[2])
			REG_GRID_WIDTH:  prdata = {{(32-CFG_W){1'b0}}, grid_width_q};
			REG_GRID_HEIGHT: prdata = {{(32-CFG_W){1'b0}}, grid_height_q};
			default:         prdata = '0;
		endcase
	end

	hbs_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.coord_x      (coord_x),
		.coord_z      (coord_z),
		.write_row    (write_row),
		.write_col    (write_col),
		.write_height (write_height),
		.grid_width   (grid_width_q),
		.grid_height  (grid_height_q),
		.clearing     (clearing),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_item       (q_item)
	);

	hbs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_item),
		.pop       (q_pop),
		.head      (q_head),
		.full      (q_full),
		.empty     (q_empty)
	);

	hbs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.clearing  (clearing),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.height    (height)
	);

endmodule

`default_nettype wire

[rtl/core/hbs_front.sv]
// Front part of the sampler: accepts input transactions, classifies them and
// turns queries into grid indexes and fractions. Depends on hbs_pkg.
`default_nettype none

module hbs_front
	import hbs_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic                      kind,
	input  wire logic signed [COORD_W-1:0] coord_x,
	input  wire logic signed [COORD_W-1:0] coord_z,
	input  wire logic [GRID_LOG2-1:0]      write_row,
	input  wire logic [GRID_LOG2-1:0]      write_col,
	input  wire logic signed [H_W-1:0]     write_height,
	input  wire logic [CFG_W-1:0]          grid_width,
	input  wire logic [CFG_W-1:0]          grid_height,
	input  wire logic                      clearing,
	input  wire logic                      q_full,
	output logic                           q_push,
	output hbs_item_t                      q_item
);

	logic      advance;
	logic      accept;
	hbs_item_t item_c;
	logic      v_s1;
	hbs_item_t item_s1;

	// The stage moves on when it is empty or its item goes into the queue.
	assign advance  = !v_s1 || !q_full;
	assign in_stall = clearing || !advance;
	assign accept   = in_valid && !in_stall;
	assign q_push   = v_s1 && !q_full;
	assign q_item   = item_s1;

	// Classify the item: a write keeps its cell, a query gets its cell and fractions.
	always_comb begin
		item_c = '0;
		item_c.kind = kind;
		item_c.data = write_height;
		if (kind == KIND_WRITE) begin
			item_c.row = write_row;
			item_c.col = write_col;
		end else begin
			item_c.row    = tile_index(coord_z, eff_size(grid_height));
			item_c.col    = tile_index(coord_x, eff_size(grid_width));
			item_c.frac_x = coord_x[FRAC_W-1:0];
			item_c.frac_z = coord_z[FRAC_W-1:0];
		end
	end

	// Stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (advance) begin
			v_s1 <= accept;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_c;
		end
	end

endmodule

`default_nettype wire

[rtl/core/hbs_queue.sv]
// Two-entry queue that decouples the front part from the back part.
// Depends on hbs_pkg for the item type.
`default_nettype none

module hbs_queue
	import hbs_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire hbs_item_t push_item,
	input  wire logic      pop,
	output hbs_item_t      head,
	output logic           full,
	output logic           empty
);

	hbs_item_t  ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign head  = ent_q[rp_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

[rtl/core/hbs_back.sv]
// Back part of the sampler: owns the height store, runs the clearing pass,
// performs writes and the four-read bilinear blend. Depends on hbs_pkg.
`default_nettype none

module hbs_back
	import hbs_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_empty,
	input  wire hbs_item_t        q_head,
	output logic                  q_pop,
	output logic                  clearing,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic signed [H_W-1:0] height
);

	hbs_state_t state_q;
	hbs_state_t state_d;
	logic [ADDR_W-1:0] clr_q;
	logic [1:0]        step_q;
	hbs_item_t         cur_q;
	logic [1:0]        pend_q;

	logic              head_write;
	logic              head_query;
	logic              credit_ok;
	logic              start;
	logic              issue;
	logic              mem_we;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_addr;
	logic [H_W-1:0]    mem_wdata;

	logic [H_W-1:0]    mem [STORE_DEPTH];
	logic [H_W-1:0]    rdata_q;

	logic [GRID_LOG2-1:0] rd_row;
	logic [GRID_LOG2-1:0] rd_col;
	logic [WT1_W-1:0]     wx;
	logic [WT1_W-1:0]     wz;
	logic [2*WT1_W-1:0]   w_full;

	logic                     v_s1;
	logic                     first_s1;
	logic                     last_s1;
	logic [WT_W-1:0]          w_s1;
	logic                     v_s2;
	logic                     first_s2;
	logic                     last_s2;
	logic signed [PROD_W-1:0] p_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  acc_c;
	logic                     res_push;

	logic [H_W-1:0] ob_q [2];
	logic           ob_wp_q;
	logic           ob_rp_q;
	logic [1:0]     ob_cnt_q;
	logic           out_take;

	// Head of the queue and room for one more result.
	assign head_write = !q_empty && (q_head.kind == KIND_WRITE);
	assign head_query = !q_empty && (q_head.kind == KIND_QUERY);
	assign credit_ok  = (pend_q != 2'd2);
	assign clearing   = (state_q == ST_CLEAR);

	// Neighbor cell and weight for the current read step.
	assign rd_row = cur_q.row + GRID_LOG2'(step_q[1]);
	assign rd_col = cur_q.col + GRID_LOG2'(step_q[0]);
	assign wx = step_q[0] ? {1'b0, cur_q.frac_x} : WT1_W'(TILE_UNITS) - {1'b0, cur_q.frac_x};
	assign wz = step_q[1] ? {1'b0, cur_q.frac_z} : WT1_W'(TILE_UNITS) - {1'b0, cur_q.frac_z};
	assign w_full = wx * wz;

	// Sequencer: clearing pass, then writes and queries from the queue.
	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		start     = 1'b0;
		issue     = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = '0;
		mem_wdata = '0;
		case (state_q)
			ST_CLEAR: begin
				mem_we   = 1'b1;
				mem_addr = clr_q;
				if (clr_q == ADDR_W'(STORE_DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (head_write) begin
					mem_we    = 1'b1;
					mem_addr  = {q_head.row, q_head.col};
					mem_wdata = q_head.data;
					q_pop     = 1'b1;
				end else if (head_query && credit_ok) begin
					q_pop   = 1'b1;
					start   = 1'b1;
					state_d = ST_QUERY;
				end
			end
			ST_QUERY: begin
				mem_re   = 1'b1;
				mem_addr = {rd_row, rd_col};
				issue    = 1'b1;
				if (step_q == 2'd3) begin
					if (head_query && credit_ok) begin
						q_pop = 1'b1;
						start = 1'b1;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			step_q  <= 2'd0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (start) begin
				step_q <= 2'd0;
			end else if (issue) begin
				step_q <= step_q + 2'd1;
			end
		end
	end

	// The query being read out.
	always_ff @(posedge clk) begin
		if (start) begin
			cur_q <= q_head;
		end
	end

	// Single-port height store with registered read data.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_addr];
		end
	end

	// Blend pipeline control flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	// Weight product alongside the read, then the weighted height.
	always_ff @(posedge clk) begin
		first_s1 <= (step_q == 2'd0);
		last_s1  <= (step_q == 2'd3);
		w_s1     <= w_full[WT_W-1:0];
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		p_s2     <= $signed(rdata_q) * $signed({1'b0, w_s1});
	end

	// Accumulate the four terms; the last one completes the floored result.
	assign acc_c    = first_s2 ? {p_s2[PROD_W-1], p_s2} : acc_q + {p_s2[PROD_W-1], p_s2};
	assign res_push = v_s2 && last_s2;

	always_ff @(posedge clk) begin
		if (v_s2) begin
			acc_q <= acc_c;
		end
		if (res_push) begin
			ob_q[ob_wp_q] <= acc_c[2*TILE_LOG2 +: H_W];
		end
	end

	// Result buffer and count of queries whose result is not yet taken.
	assign out_valid = (ob_cnt_q != 2'd0);
	assign height    = ob_q[ob_rp_q];
	assign out_take  = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_wp_q  <= 1'b0;
			ob_rp_q  <= 1'b0;
			ob_cnt_q <= 2'd0;
			pend_q   <= 2'd0;
		end else begin
			if (res_push) begin
				ob_wp_q <= !ob_wp_q;
			end
			if (out_take) begin
				ob_rp_q <= !ob_rp_q;
			end
			if (res_push && !out_take) begin
				ob_cnt_q <= ob_cnt_q + 2'd1;
			end else if (out_take && !res_push) begin
				ob_cnt_q <= ob_cnt_q - 2'd1;
			end
			if (start && !out_take) begin
				pend_q <= pend_q + 2'd1;
			end else if (out_take && !start) begin
				pend_q <= pend_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

[test/heightmap_bilinear_sampler_top_test.sv]
`timescale 1ns / 100ps
// Testbench for heightmap_bilinear_sampler_top. It writes heights into the grid
// and queries bilinear blends, then checks every result against a local model.
// It depends on hbs_pkg and the RTL of the block, and it reads no files.

module heightmap_bilinear_sampler_top_test;
	import hbs_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 24;
	localparam int MAX_PRINTED = 100;
	localparam int RANDOM_SEGMENTS = 8;
	localparam int SEGMENT_ITEMS = 180;
	localparam int SIZE_ITEMS = 12;
	localparam int TILE = 1 << TILE_LOG2;
	localparam logic [2:0] ADDR_GRID_WIDTH = 3'd0;
	localparam logic [2:0] ADDR_GRID_HEIGHT = 3'd4;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic in_valid;
	logic in_stall;
	logic kind;
	logic signed [COORD_W-1:0] coord_x;
	logic signed [COORD_W-1:0] coord_z;
	logic [GRID_LOG2-1:0] write_row;
	logic [GRID_LOG2-1:0] write_col;
	logic signed [H_W-1:0] write_height;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [H_W-1:0] height;

	// Local copy of the grid, the size registers and the heights still owed.
	logic signed [H_W-1:0] height_grid [STORE_DEPTH];
	logic [CFG_W-1:0] grid_width_reg;
	logic [CFG_W-1:0] grid_height_reg;
	logic signed [H_W-1:0] heights_due [$];
	int mismatches = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;

	heightmap_bilinear_sampler_top uut (.*);

	always #2 clk = ~clk;

	// A run that hangs ends here as a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// The receiver stalls at random with the current percentage.
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	task automatic report_mismatch(input string msg);
		if (mismatches < MAX_PRINTED) begin
			$display("MISMATCH at %0t ns: %s", $time, msg);
		end
		mismatches++;
	endtask

	// Each output transaction is compared with the oldest height owed.
	always @(posedge clk) begin
		logic signed [H_W-1:0] due;
		if (arst_n && out_valid && !out_stall) begin
			if (heights_due.size() == 0) begin
				report_mismatch($sformatf("height %0d with no query pending", height));
			end else begin
				due = heights_due.pop_front();
				if (height !== due) begin
					report_mismatch($sformatf("height %0d, expected %0d", height, due));
				end
			end
		end
	end

	// Size register as the block uses it: saturated to [2, GRID_DIM].
	function automatic int unsigned used_size(input logic [CFG_W-1:0] sz);
		if (sz < 2) return 2;
		if (sz > GRID_DIM) return GRID_DIM;
		return sz;
	endfunction

	// Grid index of a coordinate: floored tile plus half the size, clamped.
	function automatic int unsigned tile_of(input logic signed [COORD_W-1:0] pos,
		input int unsigned size);
		int t;
		t = pos;
		t = (t >>> TILE_LOG2) + int'(size / 2);
		if (t < 0) t = 0;
		if (t > int'(size) - 2) t = int'(size) - 2;
		return t;
	endfunction

	function automatic longint grid_at(input int unsigned row, input int unsigned col);
		return longint'(height_grid[{row[GRID_LOG2-1:0], col[GRID_LOG2-1:0]}]);
	endfunction

	// Bilinear blend of the four neighbors, floored back to Q8.8.
	function automatic logic signed [H_W-1:0] blend_height(
		input logic signed [COORD_W-1:0] cx,
		input logic signed [COORD_W-1:0] cz
	);
		int unsigned col;
		int unsigned row;
		longint wx1;
		longint wz1;
		longint wx0;
		longint wz0;
		longint sum;
		col = tile_of(cx, used_size(grid_width_reg));
		row = tile_of(cz, used_size(grid_height_reg));
		wx1 = cx[TILE_LOG2-1:0];
		wz1 = cz[TILE_LOG2-1:0];
		wx0 = longint'(TILE) - wx1;
		wz0 = longint'(TILE) - wz1;
		sum = grid_at(row, col) * wx0 * wz0 + grid_at(row, col + 1) * wx1 * wz0
			+ grid_at(row + 1, col) * wx0 * wz1 + grid_at(row + 1, col + 1) * wx1 * wz1;
		sum = sum >>> (2 * TILE_LOG2);
		return sum[H_W-1:0];
	endfunction

	// Sends one transaction after a random idle stretch and updates the model
	// once it is accepted. The valid stays high until the next falling edge.
	task automatic send_item(
		input logic k,
		input logic signed [COORD_W-1:0] cx,
		input logic signed [COORD_W-1:0] cz,
		input logic [GRID_LOG2-1:0] r,
		input logic [GRID_LOG2-1:0] c,
		input logic signed [H_W-1:0] h
	);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
		@(negedge clk);
		in_valid = 1'b1;
		kind = k;
		coord_x = cx;
		coord_z = cz;
		write_row = r;
		write_col = c;
		write_height = h;
		do @(posedge clk); while (in_stall);
		if (k == KIND_WRITE) begin
			height_grid[{r, c}] = h;
		end else begin
			heights_due.push_back(blend_height(cx, cz));
		end
	endtask

	task automatic write_cell(input int r, input int c, input int h);
		send_item(KIND_WRITE, COORD_W'($urandom), COORD_W'($urandom),
			GRID_LOG2'(r), GRID_LOG2'(c), H_W'(h));
	endtask

	task automatic query_point(input int x, input int z);
		send_item(KIND_QUERY, COORD_W'(x), COORD_W'(z),
			GRID_LOG2'($urandom), GRID_LOG2'($urandom), H_W'($urandom));
	endtask

	// Lowers the valid, waits for every owed height and lets writes settle.
	task automatic wait_idle();
		@(negedge clk);
		in_valid = 1'b0;
		while (heights_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = addr;
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == ADDR_GRID_WIDTH) grid_width_reg = data[CFG_W-1:0];
		else grid_height_reg = data[CFG_W-1:0];
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	// Reads one register and compares it with the local copy.
	task automatic check_register(input logic [2:0] addr);
		logic [31:0] expected;
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = addr;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		expected = (addr == ADDR_GRID_WIDTH) ? 32'(grid_width_reg) : 32'(grid_height_reg);
		if (prdata !== expected) begin
			report_mismatch($sformatf("register %0d reads %0d, expected %0d",
				addr, prdata, expected));
		end
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic set_grid(input int w, input int h);
		apb_write(ADDR_GRID_WIDTH, w);
		apb_write(ADDR_GRID_HEIGHT, h);
		check_register(ADDR_GRID_WIDTH);
		check_register(ADDR_GRID_HEIGHT);
	endtask

	// A coordinate that lands on the grid or one tile beyond either edge.
	function automatic logic signed [COORD_W-1:0] near_grid(input int unsigned size);
		int v;
		v = int'($urandom_range((size + 2) * TILE - 1)) - int'((size / 2 + 1) * TILE);
		return v[COORD_W-1:0];
	endfunction

	// Mostly writes and queries inside the grid in use, the rest anywhere.
	task automatic random_item();
		int unsigned w;
		int unsigned hgt;
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cz;
		logic [GRID_LOG2-1:0] r;
		logic [GRID_LOG2-1:0] c;
		logic signed [H_W-1:0] h;
		w = used_size(grid_width_reg);
		hgt = used_size(grid_height_reg);
		cx = COORD_W'($urandom);
		cz = COORD_W'($urandom);
		r = GRID_LOG2'($urandom);
		c = GRID_LOG2'($urandom);
		h = H_W'($urandom);
		if ($urandom_range(99) < 85) begin
			r = GRID_LOG2'($urandom_range(hgt - 1));
			c = GRID_LOG2'($urandom_range(w - 1));
			cx = near_grid(w);
			cz = near_grid(hgt);
		end
		if ($urandom_range(99) < 5) begin
			h = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
		end
		if ($urandom_range(99) < 45) send_item(KIND_WRITE, cx, cz, r, c, h);
		else send_item(KIND_QUERY, cx, cz, r, c, h);
	endtask

	task automatic set_pressure(input int sender_pct, input int receiver_pct);
		send_idle_pct = sender_pct;
		stall_pct = receiver_pct;
	endtask

	// Registers at their reset values and a store that reads as all zero.
	task automatic test_reset_state();
		check_register(ADDR_GRID_WIDTH);
		check_register(ADDR_GRID_HEIGHT);
		query_point(0, 0);
		query_point(524287, -524288);
		query_point(-129, 77);
		wait_idle();
	endtask

	// Extreme heights, fractions at both ends, far points and the clamped edges.
	task automatic test_directed();
		write_cell(20, 20, 32767);
		write_cell(20, 21, -32768);
		write_cell(21, 20, -1);
		write_cell(21, 21, 1);
		query_point(0, 0);
		query_point(255, 255);
		query_point(128, 128);
		query_point(-1, -1);
		write_cell(0, 0, -32768);
		write_cell(0, 1, 32767);
		write_cell(1, 0, 12345);
		write_cell(1, 1, -12345);
		query_point(-524288, -524288);
		query_point(-524288 + 255, -524288 + 255);
		write_cell(38, 38, 1000);
		write_cell(38, 39, -32768);
		write_cell(39, 38, 32767);
		write_cell(39, 39, -300);
		query_point(524287, 524287);
		query_point(19 * TILE, 0);
		// A write beyond the grid in use is still stored.
		write_cell(63, 63, -7);
		query_point(524287, 37);
		wait_idle();
	endtask

	task automatic try_grid(input int w, input int h);
		wait_idle();
		set_grid(w, h);
		repeat (SIZE_ITEMS) random_item();
	endtask

	// Size registers at their extremes, including values that saturate.
	task automatic test_grid_sizes();
		try_grid(2, 2);
		try_grid(64, 64);
		try_grid(0, 1);
		try_grid(127, 65);
		try_grid(2, 64);
		try_grid(64, 2);
		try_grid(40, 40);
		wait_idle();
	endtask

	// Random traffic over every idling mode with random grid sizes.
	task automatic test_random_traffic();
		int w;
		int h;
		for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
			wait_idle();
			case (seg % 4)
				0: begin
					set_pressure(0, 0);
				end
				1: begin
					set_pressure(48, 0);
				end
				2: begin
					set_pressure(0, 48);
				end
				default: begin
					set_pressure(35, 35);
				end
			endcase
			w = $urandom_range(1) ? $urandom_range(2, 12) : $urandom_range(2, 64);
			h = $urandom_range(1) ? $urandom_range(2, 12) : $urandom_range(2, 64);
			set_grid(w, h);
			repeat (SEGMENT_ITEMS) random_item();
		end
		wait_idle();
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = ADDR_GRID_WIDTH;
		pwdata = '0;
		in_valid = 1'b0;
		kind = KIND_WRITE;
		coord_x = '0;
		coord_z = '0;
		write_row = '0;
		write_col = '0;
		write_height = '0;
		grid_width_reg = 7'd40;
		grid_height_reg = 7'd40;
		for (int i = 0; i < STORE_DEPTH; i++) height_grid[i] = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_directed();
		test_grid_sizes();
		test_random_traffic();

		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
